// ===== rtl/rldq_pkg.sv =====
// Shared types and codes for the rate-limited dispatch queue.
package rldq_pkg;

  typedef enum logic [2:0] {
    FUNC_SCHEDULE   = 3'd0,
    FUNC_CLEAR      = 3'd1,
    FUNC_PAUSE      = 3'd2,
    FUNC_RESUME     = 3'd3,
    FUNC_TICK       = 3'd4,
    FUNC_OWNER_GONE = 3'd5
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISPATCH
  } state_e;

  localparam logic [15:0] IntervalReset = 16'd1000;
  localparam logic [15:0] TicksMax      = 16'hFFFF;

  typedef struct packed {
    logic [15:0] tag;
    logic [3:0]  owner;
    logic        has_owner;
    logic        cancelled;
  } entry_t;

  typedef struct packed {
    logic       shift_r;    // push at front: every cell takes its left neighbour
    logic       shift_l;    // pop at front: every cell takes its right neighbour
    logic       load_back;  // push at back: the cell at the fill position loads
    logic       cancel_en;
    logic [3:0] cancel_owner;
  } chain_ctrl_t;

endpackage

// ===== rtl/rldq_cell.sv =====
// One queue cell: holds an entry, shifts either way, loads or cancels it.
module rldq_cell
  import rldq_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        load_i,
  input  entry_t      new_i,
  input  entry_t      left_i,
  input  entry_t      right_i,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = new_i;
    end else if (ctrl_i.shift_r) begin
      entry_d = left_i;
    end else if (ctrl_i.shift_l) begin
      entry_d = right_i;
    end
    if (ctrl_i.cancel_en && entry_q.has_owner && (entry_q.owner == ctrl_i.cancel_owner)) begin
      entry_d.cancelled = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/rldq_chain.sv =====
// Row of queue cells, front at cell 0.
module rldq_chain
  import rldq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  chain_ctrl_t   ctrl_i,
  input  logic [CW-1:0] back_pos_i,
  input  entry_t        new_i,
  output entry_t        head_o
);

  entry_t cell_q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left, right;
    logic   load;

    if (i == 0) begin : g_first
      assign left = new_i;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner
      assign right = cell_q[i+1];
    end

    assign load = ctrl_i.load_back && (back_pos_i == CW'(i));

    rldq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .load_i  (load),
      .new_i   (new_i),
      .left_i  (left),
      .right_i (right),
      .entry_o (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== rtl/rate_limited_dispatch_queue.sv =====
// Top level of the rate-limited dispatch queue.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+---------------------------
//  command   | func_i request_tag_i owner_id_i has_owner_i      | start_i while busy_o low
//            | high_priority_i                                  |
//  result    | dispatched_o dispatched_tag_o overflow_o         | done_o, one cycle
//            | is_paused_o queue_count_o                        |
//  config    | interval_wdata_i                                 | interval_we_i
//
// Items that attempt no dispatch give their result the cycle after the beat.
// A dispatch attempt walks the front of the cell row, one entry removed per
// cycle, until it dispatches a live entry or finds the queue empty or paused;
// busy_o is high meanwhile.
// Reset clears control state, interval_q to IntervalReset; cells undefined until written.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
module rate_limited_dispatch_queue
  import rldq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] request_tag_i,
  input  logic [3:0]  owner_id_i,
  input  logic        has_owner_i,
  input  logic        high_priority_i,
  input  logic        interval_we_i,
  input  logic [15:0] interval_wdata_i,
  output logic        done_o,
  output logic        dispatched_o,
  output logic [15:0] dispatched_tag_o,
  output logic        overflow_o,
  output logic        is_paused_o,
  output logic [4:0]  queue_count_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   ticks_q, ticks_d;
  logic [15:0]   cd_q, cd_d;
  logic          armed_q, armed_d;
  logic          paused_q, paused_d;
  logic [15:0]   interval_q, interval_d;
  logic          done_q, done_d;
  logic          disp_q, disp_d;
  logic [15:0]   tag_q, tag_d;
  logic          ovf_q, ovf_d;

  chain_ctrl_t ctrl;
  entry_t      new_entry, head;
  func_e       func;
  logic        accept, full, ticks_ge, tick_fire, go_disp, head_skip, empty_or_paused;
  logic [15:0] cd_dec;
  logic [31:0] count_ext;

  assign func            = func_e'(func_i);
  assign accept          = start_i && (state_q == ST_IDLE);
  assign full            = (count_q == CW'(QUEUE_DEPTH));
  assign ticks_ge        = (ticks_q >= interval_q);
  assign cd_dec          = (cd_q != 16'd0) ? cd_q - 16'd1 : 16'd0;
  assign tick_fire       = armed_q && (cd_dec == 16'd0);
  assign head_skip       = head.has_owner && head.cancelled;
  assign empty_or_paused = (count_q == '0) || paused_q;
  assign go_disp         = accept && (((func == FUNC_SCHEDULE) && !full && ticks_ge)
                                   || ((func == FUNC_TICK) && tick_fire));

  assign new_entry.tag       = request_tag_i;
  assign new_entry.owner     = owner_id_i;
  assign new_entry.has_owner = has_owner_i;
  assign new_entry.cancelled = 1'b0;

  assign interval_d = interval_we_i ? interval_wdata_i : interval_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go_disp) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (empty_or_paused || !head_skip) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    count_d  = count_q;
    ticks_d  = ticks_q;
    cd_d     = cd_q;
    armed_d  = armed_q;
    paused_d = paused_q;
    done_d   = 1'b0;
    disp_d   = 1'b0;
    tag_d    = 16'd0;
    ovf_d    = 1'b0;
    ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_SCHEDULE: begin
              if (full) begin
                ovf_d  = 1'b1;
                done_d = 1'b1;
              end else begin
                if (high_priority_i) begin
                  ctrl.shift_r = 1'b1;
                end else begin
                  ctrl.load_back = 1'b1;
                end
                count_d = count_q + CW'(1);
                if (!ticks_ge) begin
                  done_d = 1'b1;
                  if (count_q == '0) begin
                    cd_d    = interval_q - ticks_q;
                    armed_d = 1'b1;
                  end
                end
              end
            end
            FUNC_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            FUNC_PAUSE: begin
              paused_d = 1'b1;
              armed_d  = 1'b0;
              done_d   = 1'b1;
            end
            FUNC_RESUME: begin
              paused_d = 1'b0;
              cd_d     = interval_q;
              armed_d  = 1'b1;
              done_d   = 1'b1;
            end
            FUNC_TICK: begin
              if (ticks_q != TicksMax) begin
                ticks_d = ticks_q + 16'd1;
              end
              if (armed_q) begin
                cd_d = cd_dec;
                if (cd_dec == 16'd0) begin
                  armed_d = 1'b0;
                end
              end
              done_d = !tick_fire;
            end
            FUNC_OWNER_GONE: begin
              ctrl.cancel_en    = 1'b1;
              ctrl.cancel_owner = owner_id_i;
              done_d            = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_DISPATCH: begin
        if (empty_or_paused) begin
          done_d = 1'b1;
        end else begin
          ctrl.shift_l = 1'b1;
          count_d      = count_q - CW'(1);
          if (!head_skip) begin
            done_d  = 1'b1;
            disp_d  = 1'b1;
            tag_d   = head.tag;
            ticks_d = 16'd0;
            if (count_q != CW'(1)) begin
              cd_d    = interval_q;
              armed_d = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  rldq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .back_pos_i (count_q),
    .new_i      (new_entry),
    .head_o     (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      ticks_q    <= 16'd0;
      cd_q       <= 16'd0;
      armed_q    <= 1'b0;
      paused_q   <= 1'b0;
      interval_q <= IntervalReset;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ticks_q    <= ticks_d;
      cd_q       <= cd_d;
      armed_q    <= armed_d;
      paused_q   <= paused_d;
      interval_q <= interval_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disp_q <= disp_d;
    tag_q  <= tag_d;
    ovf_q  <= ovf_d;
  end

  // pause state and fill level are already post-beat while done_o is high
  assign count_ext        = 32'(count_q);
  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign dispatched_o     = disp_q;
  assign dispatched_tag_o = tag_q;
  assign overflow_o       = ovf_q;
  assign is_paused_o      = paused_q;
  assign queue_count_o    = count_ext[4:0];

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the rate-limited dispatch queue.
module testbench;
  import rldq_pkg::*;

  localparam int          QDEPTH        = 16;
  localparam int          IdleLimit     = 2000;
  localparam logic [2:0]  FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;

  typedef struct packed {
    logic        dispatched;
    logic [15:0] tag;
    logic        overflow;
    logic        paused;
    logic [4:0]  count;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  func_i = FUNC_CLEAR;
  logic [15:0] request_tag_i = '0;
  logic [3:0]  owner_id_i = '0;
  logic        has_owner_i = 1'b0;
  logic        high_priority_i = 1'b0;
  logic        interval_we_i = 1'b0;
  logic [15:0] interval_wdata_i = '0;
  logic        done_o;
  logic        dispatched_o;
  logic [15:0] dispatched_tag_o;
  logic        overflow_o;
  logic        is_paused_o;
  logic [4:0]  queue_count_o;

  // queue model
  entry_t      mdl_cells [QDEPTH];
  int unsigned mdl_head;
  int unsigned mdl_count;
  logic [15:0] mdl_since;
  logic [15:0] mdl_cd;
  logic        mdl_armed;
  logic        mdl_paused;
  logic [15:0] mdl_interval;

  result_t     due_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  rate_limited_dispatch_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .request_tag_i   (request_tag_i),
    .owner_id_i      (owner_id_i),
    .has_owner_i     (has_owner_i),
    .high_priority_i (high_priority_i),
    .interval_we_i   (interval_we_i),
    .interval_wdata_i(interval_wdata_i),
    .done_o          (done_o),
    .dispatched_o    (dispatched_o),
    .dispatched_tag_o(dispatched_tag_o),
    .overflow_o      (overflow_o),
    .is_paused_o     (is_paused_o),
    .queue_count_o   (queue_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pop front entries until a live one turns up; cancelled ones are dropped.
  function automatic logic pop_live_entry(output logic [15:0] tag);
    entry_t e;
    tag = '0;
    while (mdl_count != 0 && !mdl_paused) begin
      e = mdl_cells[mdl_head];
      mdl_head = (mdl_head + 1) % QDEPTH;
      mdl_count--;
      if (!(e.has_owner && e.cancelled)) begin
        tag = e.tag;
        mdl_since = '0;
        if (mdl_count != 0) begin
          mdl_cd = mdl_interval;
          mdl_armed = 1'b1;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(logic [2:0] func, logic [15:0] tag,
                                             logic [3:0] owner, logic has_owner,
                                             logic high);
    result_t     r;
    entry_t      e;
    int unsigned pos;
    logic [15:0] out_tag;
    r = '0;
    out_tag = '0;
    case (func)
      FUNC_SCHEDULE: begin
        if (mdl_count >= QDEPTH) begin
          r.overflow = 1'b1;
        end else begin
          e.tag = tag;
          e.owner = owner;
          e.has_owner = has_owner;
          e.cancelled = 1'b0;
          if (high) begin
            mdl_head = (mdl_head + QDEPTH - 1) % QDEPTH;
            pos = mdl_head;
          end else begin
            pos = (mdl_head + mdl_count) % QDEPTH;
          end
          mdl_cells[pos] = e;
          mdl_count++;
          if (mdl_since >= mdl_interval) begin
            r.dispatched = pop_live_entry(out_tag);
          end else if (mdl_count == 1) begin
            mdl_cd = mdl_interval - mdl_since;
            mdl_armed = 1'b1;
          end
        end
      end
      FUNC_CLEAR: mdl_count = 0;
      FUNC_PAUSE: begin
        mdl_paused = 1'b1;
        mdl_armed = 1'b0;
      end
      FUNC_RESUME: begin
        mdl_paused = 1'b0;
        mdl_cd = mdl_interval;
        mdl_armed = 1'b1;
      end
      FUNC_TICK: begin
        if (mdl_since != TicksMax) mdl_since++;
        if (mdl_armed) begin
          if (mdl_cd != 0) mdl_cd--;
          if (mdl_cd == 0) begin
            mdl_armed = 1'b0;
            r.dispatched = pop_live_entry(out_tag);
          end
        end
      end
      FUNC_OWNER_GONE: begin
        for (int unsigned i = 0; i < mdl_count; i++) begin
          pos = (mdl_head + i) % QDEPTH;
          if (mdl_cells[pos].has_owner && mdl_cells[pos].owner == owner)
            mdl_cells[pos].cancelled = 1'b1;
        end
      end
      default: ;
    endcase
    r.tag = r.dispatched ? out_tag : 16'h0000;
    r.paused = mdl_paused;
    r.count = mdl_count[4:0];
    return r;
  endfunction

  // One command beat; start stays high afterwards so beats can run back to back.
  task automatic send_cmd(logic [2:0] func, logic [15:0] tag = '0, logic [3:0] owner = '0,
                          logic has_owner = 1'b0, logic high = 1'b0);
    @(negedge clk_i);
    func_i = func;
    request_tag_i = tag;
    owner_id_i = owner;
    has_owner_i = has_owner;
    high_priority_i = high;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    due_results.push_back(predict_result(func, tag, owner, has_owner, high));
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_quiet();
    hold_off(1);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (QDEPTH + 4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_interval(logic [15:0] value);
    wait_quiet();
    @(negedge clk_i);
    interval_we_i = 1'b1;
    interval_wdata_i = value;
    @(negedge clk_i);
    interval_we_i = 1'b0;
    interval_wdata_i = $urandom();
    mdl_interval = value;
  endtask

  task automatic send_random_cmd();
    int          pick;
    logic [2:0]  func;
    logic [3:0]  owner;
    pick = $urandom_range(0, 99);
    if (pick < 38)      func = FUNC_SCHEDULE;
    else if (pick < 80) func = FUNC_TICK;
    else if (pick < 87) func = FUNC_OWNER_GONE;
    else if (pick < 91) func = FUNC_PAUSE;
    else if (pick < 96) func = FUNC_RESUME;
    else if (pick < 98) func = FUNC_CLEAR;
    else                func = pick[0] ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    // a narrow owner set makes cancellation hit held entries
    owner = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    send_cmd(func, 16'($urandom()), owner, 1'($urandom()), 1'($urandom()));
  endtask

  task automatic test_reset_interval();
    send_cmd(FUNC_SCHEDULE, 16'h0000, 4'd0, 1'b0, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'hFFFF, 4'd15, 1'b1, 1'b1);
    send_cmd(FUNC_TICK);
    send_cmd(FUNC_CLEAR);
  endtask

  task automatic test_zero_interval();
    set_interval(16'd0);
    send_cmd(FUNC_SCHEDULE, 16'hA5A5, 4'd1, 1'b0, 1'b0);
    send_cmd(FUNC_PAUSE);
    send_cmd(FUNC_SCHEDULE, 16'h5A5A, 4'd2, 1'b1, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h1234, 4'd3, 1'b0, 1'b1);
    send_cmd(FUNC_RESUME);
    send_cmd(FUNC_TICK);    // countdown armed with zero fires at once
    send_cmd(FUNC_TICK);
    send_cmd(FUNC_SPARE_LO, 16'hFFFF, 4'hF, 1'b1, 1'b1);
    send_cmd(FUNC_SPARE_HI, 16'hFFFF, 4'hF, 1'b1, 1'b1);
  endtask

  task automatic test_cancel_skip();
    set_interval(16'd2);
    send_cmd(FUNC_SCHEDULE, 16'h0101, 4'd2, 1'b1, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h0202, 4'd2, 1'b0, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h0303, 4'd5, 1'b1, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h0404, 4'd2, 1'b1, 1'b1);
    send_cmd(FUNC_OWNER_GONE, 16'h0000, 4'd2);
    repeat (8) send_cmd(FUNC_TICK);
    // whole queue cancelled: the walk empties it and dispatches nothing
    send_cmd(FUNC_SCHEDULE, 16'h0707, 4'd7, 1'b1, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h0808, 4'd7, 1'b1, 1'b0);
    send_cmd(FUNC_OWNER_GONE, 16'h0000, 4'd7);
    repeat (4) send_cmd(FUNC_TICK);
    // clear with the countdown still running
    send_cmd(FUNC_SCHEDULE, 16'h0909, 4'd0, 1'b0, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'h0A0A, 4'd0, 1'b0, 1'b0);
    send_cmd(FUNC_CLEAR);
    repeat (3) send_cmd(FUNC_TICK);
  endtask

  task automatic test_full_queue();
    set_interval(16'hFFFF);
    for (int i = 0; i < QDEPTH; i++)
      send_cmd(FUNC_SCHEDULE, 16'($urandom()), 4'(i), 1'(i), 1'(i >> 1));
    send_cmd(FUNC_SCHEDULE, 16'hDEAD, 4'd0, 1'b0, 1'b0);
    send_cmd(FUNC_SCHEDULE, 16'hBEEF, 4'd1, 1'b1, 1'b1);
    send_cmd(FUNC_CLEAR);
  endtask

  // elapsed count short of the interval arms the remainder, past it dispatches at once
  task automatic test_elapsed_ticks();
    send_cmd(FUNC_RESUME);
    send_cmd(FUNC_CLEAR);
    set_interval(16'd0);
    send_cmd(FUNC_SCHEDULE, 16'h1111, 4'd0, 1'b0, 1'b0);
    set_interval(16'd20);
    repeat (18) send_cmd(FUNC_TICK);
    send_cmd(FUNC_SCHEDULE, 16'h2222, 4'd0, 1'b0, 1'b0);
    send_cmd(FUNC_TICK);
    repeat (24) send_cmd(FUNC_TICK);
    send_cmd(FUNC_SCHEDULE, 16'h3333, 4'd0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(logic [15:0] interval, int beats);
    int sent;
    int burst;
    set_interval(interval);
    sent = 0;
    while (sent < beats) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) send_random_cmd();
      sent += burst;
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (dispatched_o !== want.dispatched) begin
          $display("%0t: dispatched exp %0d got %0d", $time, want.dispatched, dispatched_o);
          mismatches++;
        end
        if (dispatched_tag_o !== want.tag) begin
          $display("%0t: dispatched_tag exp %h got %h", $time, want.tag, dispatched_tag_o);
          mismatches++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow exp %0d got %0d", $time, want.overflow, overflow_o);
          mismatches++;
        end
        if (is_paused_o !== want.paused) begin
          $display("%0t: is_paused exp %0d got %0d", $time, want.paused, is_paused_o);
          mismatches++;
        end
        if (queue_count_o !== want.count) begin
          $display("%0t: queue_count exp %0d got %0d", $time, want.count, queue_count_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles with neither a command beat nor a result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    mdl_head = 0;
    mdl_count = 0;
    mdl_since = '0;
    mdl_cd = '0;
    mdl_armed = 1'b0;
    mdl_paused = 1'b0;
    mdl_interval = IntervalReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_interval();
    test_zero_interval();
    test_cancel_skip();
    test_full_queue();
    test_elapsed_ticks();
    test_random_traffic(16'd0, 80);
    test_random_traffic(16'd1, 90);
    test_random_traffic(16'd3, 90);
    test_random_traffic(16'($urandom_range(2, 12)), 90);
    test_random_traffic(16'hFFFF, 70);
    test_random_traffic(16'd5, 90);
    test_random_traffic(IntervalReset, 70);
    test_random_traffic(16'($urandom_range(0, 20)), 80);

    wait_quiet();
    repeat (QDEPTH * 2) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      mismatches++;
    end
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rldq_pkg.sv
rtl/rldq_cell.sv
rtl/rldq_chain.sv
rtl/rate_limited_dispatch_queue.sv
dv/testbench.sv
